@@ hdl/fspl_pkg.sv @@
// fspl_pkg: types and constants for the flow state priority list manager
// no dependencies
package fspl_pkg;

  typedef enum logic [2:0] {
    ST_NULL  = 3'd0,
    ST_UNDES = 3'd1,
    ST_UNAV  = 3'd2,
    ST_MON   = 3'd3,
    ST_UNMON = 3'd4
  } flow_state_t;

  typedef enum logic [1:0] {
    CMD_ALLOC    = 2'd0,
    CMD_CHANGE   = 2'd1,
    CMD_READ_DES = 2'd2,
    CMD_READ_UND = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_ILLEGAL  = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_BEYOND   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FREE_SCAN,
    S_CHECK,
    S_REM_FIND,
    S_REM_SHIFT,
    S_ENTRY,
    S_INS_FIND,
    S_INS_SHIFT,
    S_ALLOC_SHIFT,
    S_DONE
  } seq_state_t;

  localparam logic [0:0] REG_TEST_MODE = 1'b0;

  // legal[from][to]
  function automatic logic legal_change(input logic [2:0] from, input logic [2:0] to);
    logic r;
    r = 1'b0;
    case (from)
      ST_NULL:  r = (to == ST_UNAV);
      ST_UNDES: r = (to == ST_NULL) || (to == ST_UNAV);
      ST_UNAV:  r = (to == ST_NULL) || (to == ST_UNDES) || (to == ST_MON) || (to == ST_UNMON);
      ST_MON:   r = (to == ST_NULL) || (to == ST_UNDES) || (to == ST_UNAV) || (to == ST_UNMON);
      ST_UNMON: r = (to == ST_NULL) || (to == ST_UNDES) || (to == ST_UNAV) || (to == ST_MON);
      default:  r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/fspl_if.sv @@
// fspl_if: valid/ready channel interfaces for request and result
// depends on nothing; payload widths fixed by the field list
interface fspl_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [3:0] flow_handle;
  logic [2:0] target_state;
  logic [7:0] flow_priority;
  logic [3:0] list_position;
  logic       protocol_open;
  modport source (output valid, command, flow_handle, target_state, flow_priority,
                  list_position, protocol_open, input ready);
  modport sink (input valid, command, flow_handle, target_state, flow_priority,
                list_position, protocol_open, output ready);
endinterface

interface fspl_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [3:0] handle_out;
  logic       enable_flow;
  logic       disable_flow;
  logic       monitoring_started;
  logic       monitoring_stopped;
  logic [4:0] monitored_count;
  logic [4:0] desired_count;
  logic [4:0] undesired_count;
  logic [4:0] free_count;
  modport source (output valid, status, handle_out, enable_flow, disable_flow,
                  monitoring_started, monitoring_stopped, monitored_count,
                  desired_count, undesired_count, free_count, input ready);
  modport sink (input valid, status, handle_out, enable_flow, disable_flow,
                monitoring_started, monitoring_stopped, monitored_count,
                desired_count, undesired_count, free_count, output ready);
endinterface

@@ hdl/flow_state_priority_list_manager.sv @@
// flow_state_priority_list_manager: top level, sequencer and list storage
// depends on fspl_pkg and fspl_if
//
//  channel | direction | protocol
//  req     | in        | valid/ready, one request per command
//  rsp     | out       | valid/ready, one result per request
//  apb     | in        | apb write/read, register 0 = test_mode
//
// list walks step one entry per cycle through a single shared
// compare/index unit
// free-pool membership check, list removal and sorted insertion each walk a list
// synchronous active-high reset loads the free pool with all entries in index order
// ready is low from acceptance until the result has been taken
module flow_state_priority_list_manager #(
  parameter int NUM_FLOWS     = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  fspl_req_if.sink    req,
  fspl_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fspl_pkg::*;

  localparam int HW = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;
  localparam int CW = $clog2(NUM_FLOWS + 1);
  localparam logic [CW-1:0] NF = CW'(NUM_FLOWS);

  // storage (registers, read at sequencer-chosen index)
  logic [2:0]               entry_state [NUM_FLOWS];
  logic [PRIORITY_BITS-1:0] entry_priority [NUM_FLOWS];
  logic [HW-1:0]            des_list [NUM_FLOWS];
  logic [HW-1:0]            und_list [NUM_FLOWS];
  logic [HW-1:0]            free_pool [NUM_FLOWS];
  logic [CW-1:0]            des_cnt, und_cnt, free_cnt, mon_cnt;
  logic                     test_mode;

  // latched request
  logic [1:0]  cmd;
  logic [3:0]  hdl_in;
  logic [2:0]  tgt;
  logic [PRIORITY_BITS-1:0] prio;
  logic [3:0]  pos;
  logic        open_r;
  logic [2:0]  cur;
  logic        which_des;  // removal list select

  seq_state_t state, state_next;
  logic [CW-1:0] idx;
  logic [HW-1:0] h;
  logic          found;

  // result
  logic [1:0] r_status;
  logic [3:0] r_hout;
  logic r_en, r_dis, r_start, r_stop;

  assign h = hdl_in[HW-1:0];
  assign pready = 1'b1;
  assign prdata = (paddr == 2'b00) ? {31'd0, test_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) test_mode <= 1'b0;
    else if (psel && penable && pwrite && paddr[1:0] == {1'b0, REG_TEST_MODE})
      test_mode <= pwdata[0];
  end

  // shared compare unit: one list element per cycle
  logic [HW-1:0] idx_h;
  logic          hit_free, hit_rem, ins_stop;
  assign idx_h    = idx[HW-1:0];
  assign hit_free = (32'(hdl_in) < NUM_FLOWS) && (free_pool[idx_h] == h);
  assign hit_rem  = which_des ? (des_list[idx_h] == h) : (und_list[idx_h] == h);
  assign ins_stop = prio < entry_priority[des_list[idx_h]];

  logic tgt_ok;
  assign tgt_ok = (tgt <= ST_UNMON) && (32'(hdl_in) < NUM_FLOWS) &&
                  legal_change(cur, tgt);

  // insertion position held in ins_pos, shift index in sh
  logic [CW-1:0] ins_pos, sh;
  logic [CW-1:0] mon_dec;
  assign mon_dec = (mon_cnt > '0) ? mon_cnt - 1'b1 : mon_cnt;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (req.valid) state_next = S_DECODE;
      S_DECODE: begin
        if (cmd == CMD_ALLOC) state_next = (free_cnt == '0) ? S_DONE : S_ALLOC_SHIFT;
        else if (cmd == CMD_CHANGE) state_next = S_FREE_SCAN;
        else state_next = S_DONE;
      end
      S_FREE_SCAN: begin
        if (!tgt_ok || cur != ST_NULL || idx >= free_cnt) state_next = S_CHECK;
        else if (hit_free) state_next = S_CHECK;
      end
      S_CHECK: state_next = (!tgt_ok || found) ? S_DONE : S_REM_FIND;
      S_REM_FIND: begin
        if (!found) state_next = S_ENTRY;
        else if (idx >= (which_des ? des_cnt : und_cnt)) state_next = S_ENTRY;
        else if (hit_rem) state_next = S_REM_SHIFT;
      end
      S_REM_SHIFT:
        if (idx + 1'b1 >= (which_des ? des_cnt : und_cnt)) state_next = S_ENTRY;
      S_ENTRY:
        state_next = (tgt == ST_UNAV && (cur == ST_NULL || cur == ST_UNDES) &&
                      des_cnt < NF) ? S_INS_FIND : S_DONE;
      S_INS_FIND:
        if (test_mode || idx >= des_cnt || ins_stop) state_next = S_INS_SHIFT;
      S_INS_SHIFT: if (sh <= ins_pos) state_next = S_DONE;
      S_ALLOC_SHIFT: if (idx + 1'b1 >= free_cnt) state_next = S_DONE;
      S_DONE: if (rsp.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req.ready = (state == S_IDLE);
    rsp.valid = (state == S_DONE);
  end
  assign rsp.status = r_status;
  assign rsp.handle_out = r_hout;
  assign rsp.enable_flow = r_en;
  assign rsp.disable_flow = r_dis;
  assign rsp.monitoring_started = r_start;
  assign rsp.monitoring_stopped = r_stop;
  assign rsp.monitored_count = 5'(mon_cnt);
  assign rsp.desired_count = 5'(des_cnt);
  assign rsp.undesired_count = 5'(und_cnt);
  assign rsp.free_count = 5'(free_cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      des_cnt <= '0;
      und_cnt <= '0;
      free_cnt <= NF;
      mon_cnt <= '0;
      for (int i = 0; i < NUM_FLOWS; i++) begin
        entry_state[i] <= ST_NULL;
        free_pool[i] <= HW'(i);
      end
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: if (req.valid) begin
          cmd <= req.command;
          hdl_in <= req.flow_handle;
          tgt <= req.target_state;
          prio <= req.flow_priority[PRIORITY_BITS-1:0];
          pos <= req.list_position;
          open_r <= req.protocol_open;
          cur <= entry_state[req.flow_handle[HW-1:0]];
          r_status <= STAT_OK; r_hout <= '0;
          r_en <= 1'b0; r_dis <= 1'b0; r_start <= 1'b0; r_stop <= 1'b0;
          idx <= '0;
          found <= 1'b0;
        end
        S_DECODE: begin
          if (cmd == CMD_ALLOC) begin
            if (free_cnt == '0) r_status <= STAT_EMPTY;
            else r_hout <= 4'(free_pool[0]);
          end else if (cmd == CMD_READ_DES || cmd == CMD_READ_UND) begin
            if (5'(pos) >= 5'(cmd == CMD_READ_DES ? des_cnt : und_cnt) ||
                32'(pos) >= NUM_FLOWS)
              r_status <= STAT_BEYOND;
            else r_hout <= 4'(cmd == CMD_READ_DES ? des_list[pos[HW-1:0]]
                                                   : und_list[pos[HW-1:0]]);
          end
        end
        S_FREE_SCAN: begin
          if (tgt_ok && cur == ST_NULL && idx < free_cnt && hit_free) found <= 1'b1;
          idx <= idx + 1'b1;
        end
        S_CHECK: begin
          idx <= '0;
          if (!tgt_ok || found) r_status <= STAT_ILLEGAL;
          else begin
            // exit bookkeeping; found now flags "remove from a list"
            found <= 1'b0;
            if (cur == ST_UNDES && (tgt == ST_NULL || tgt == ST_UNAV)) begin
              found <= 1'b1; which_des <= 1'b0;
            end else if (cur >= ST_UNAV && (tgt == ST_NULL || tgt == ST_UNDES)) begin
              found <= 1'b1; which_des <= 1'b1;
            end
            if (cur == ST_MON) begin
              r_dis <= 1'b1;
              mon_cnt <= mon_dec;
              if (open_r && mon_dec == '0) r_stop <= 1'b1;
            end
          end
        end
        S_REM_FIND: if (found) begin
          if (idx < (which_des ? des_cnt : und_cnt)) begin
            if (hit_rem) begin
              if (idx + 1'b1 >= (which_des ? des_cnt : und_cnt)) begin
                if (which_des) des_cnt <= des_cnt - 1'b1;
                else und_cnt <= und_cnt - 1'b1;
              end
            end else idx <= idx + 1'b1;
          end
        end
        S_REM_SHIFT: begin
          if (idx + 1'b1 < (which_des ? des_cnt : und_cnt)) begin
            if (which_des) des_list[idx_h] <= des_list[HW'(idx + 1'b1)];
            else und_list[idx_h] <= und_list[HW'(idx + 1'b1)];
            idx <= idx + 1'b1;
            if (idx + 2'd2 >= (which_des ? des_cnt : und_cnt)) begin
              if (which_des) des_cnt <= des_cnt - 1'b1;
              else und_cnt <= und_cnt - 1'b1;
            end
          end
        end
        S_ENTRY: begin
          entry_state[h] <= tgt;
          idx <= '0;
          case (tgt)
            ST_NULL: if (free_cnt < NF) begin
              free_pool[free_cnt[HW-1:0]] <= h;
              free_cnt <= free_cnt + 1'b1;
            end
            ST_UNDES: if (und_cnt < NF) begin
              und_list[und_cnt[HW-1:0]] <= h;
              und_cnt <= und_cnt + 1'b1;
            end
            ST_UNAV: if (cur == ST_NULL || cur == ST_UNDES) entry_priority[h] <= prio;
            ST_MON: begin
              r_en <= 1'b1;
              if (mon_cnt == '0) r_start <= 1'b1;
              if (mon_cnt < NF) mon_cnt <= mon_cnt + 1'b1;
            end
            default: ;
          endcase
        end
        S_INS_FIND: begin
          if (test_mode || idx >= des_cnt || ins_stop) begin
            ins_pos <= test_mode ? des_cnt : idx;
            sh <= des_cnt;
          end else idx <= idx + 1'b1;
        end
        default: ;
      endcase
      // insertion shift: walk from the tail to the insertion point
      if (state == S_INS_SHIFT) begin
        if (sh > ins_pos) begin
          des_list[sh[HW-1:0]] <= des_list[HW'(sh - 1'b1)];
          sh <= sh - 1'b1;
        end else begin
          des_list[ins_pos[HW-1:0]] <= h;
          des_cnt <= des_cnt + 1'b1;
        end
      end
      // free pool pops its head: shift up, count drops on the last step
      if (state == S_ALLOC_SHIFT) begin
        if (idx + 1'b1 < free_cnt) begin
          free_pool[idx_h] <= free_pool[HW'(idx + 1'b1)];
          idx <= idx + 1'b1;
        end
        if (idx + 1'b1 >= free_cnt) free_cnt <= free_cnt - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_count_total: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (32'(des_cnt) + 32'(und_cnt) + 32'(free_cnt) <= NUM_FLOWS))
    else $error("list counts exceed pool");
  a_mon_bound: assert property (@(posedge clk) disable iff (rst)
    32'(mon_cnt) <= NUM_FLOWS) else $error("monitored count overflow");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready) else $error("accepted while busy");
  a_pulses: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.enable_flow && rsp.monitoring_stopped))
    else $error("enable and stop together");
`endif
endmodule
